// ===== rtl/core/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types and constants of the depth box centroid block: register map,
// reset values, result widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dbc_pkg;

    // register map, index = byte address / 4
    localparam logic [2:0] REG_MAX_RANGE  = 3'd0;
    localparam logic [2:0] REG_CENTER_COL = 3'd1;
    localparam logic [2:0] REG_CENTER_ROW = 3'd2;
    localparam logic [2:0] REG_FOCAL_COL  = 3'd3;
    localparam logic [2:0] REG_FOCAL_ROW  = 3'd4;

    localparam logic [15:0] RST_MAX_RANGE  = 16'd10000;
    localparam logic [15:0] RST_CENTER_COL = 16'd5120;
    localparam logic [15:0] RST_CENTER_ROW = 16'd3840;
    localparam logic [15:0] RST_FOCAL_COL  = 16'd8192;
    localparam logic [15:0] RST_FOCAL_ROW  = 16'd8192;

    localparam logic [15:0] MIN_DEPTH_MM = 16'd100;
    localparam logic [15:0] FOCAL_MIN    = 16'd16;

    // result widths
    localparam int XY_W = 19;
    localparam int Z_W  = 16;
    localparam int KC_W = 21;
    localparam int Q_W  = 19;

    localparam logic [XY_W-1:0] XY_POS_MAX = 19'h3FFFF;
    localparam logic [XY_W-1:0] XY_NEG_MIN = 19'h40000;

    // which quotient the shared divider is working on
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_X = 2'd0;
    localparam t_sel SEL_Y = 2'd1;
    localparam t_sel SEL_Z = 2'd2;

    typedef struct packed {
        logic ready;   // pixel intake open
        logic prep;    // register divider operands
        logic start;   // launch divider
        logic store;   // keep finished quotient
        logic load;    // move results into output register
        logic clr;     // clear sums for next box
        t_sel sel;
    } t_dbc_cmd;

    typedef struct packed {
        logic last_done;
        logic tally_zero;
        logic div_done;
    } t_dbc_stat;

endpackage

// ===== rtl/core/dbc_div.sv =====
// ----------------------------------------------------------------------------
// dbc_div
// Restoring divider, one quotient bit per cycle. Produces a Q_W-bit quotient
// and flags overflow when the true quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module dbc_div #(
    parameter int DVD_W = 54,
    parameter int DEN_W = 37
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dvd,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic               o_ovf,
    output logic [dbc_pkg::Q_W-1:0] o_quo
);
    import dbc_pkg::*;

    localparam int HI_W  = DVD_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;

    logic [DEN_W:0]   w_trial;
    logic             w_fit;
    logic             w_ovf;

    assign w_trial = {r_rem, r_low[Q_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_ovf   = (CMP_W'(i_dvd[DVD_W-1:Q_W]) >= CMP_W'(i_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high part is below the divisor unless the quotient overflows
            r_rem <= DEN_W'(i_dvd[DVD_W-1:Q_W]);
            r_low <= i_dvd[Q_W-1:0];
            r_den <= i_den;
            r_ovf <= w_ovf;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/dbc_datapath.sv =====
// ----------------------------------------------------------------------------
// dbc_datapath
// Pixel filter, back-projection multiply and accumulate pipeline, divider
// operand selection, saturation and the result register.
// ----------------------------------------------------------------------------
module dbc_datapath #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_BOX_PIXELS = 1048576,
    parameter int TALLY_W        = 21
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dbc_pkg::t_dbc_cmd       i_cmd,
    output dbc_pkg::t_dbc_stat      o_stat,
    input  logic                    i_take,
    input  logic [15:0]             i_depth_mm,
    input  logic [COORD_BITS-1:0]   i_pixel_col,
    input  logic [COORD_BITS-1:0]   i_pixel_row,
    input  logic                    i_box_last,
    input  logic [15:0]             i_max_range_mm,
    input  logic [15:0]             i_center_col,
    input  logic [15:0]             i_center_row,
    input  logic [15:0]             i_focal_col,
    input  logic [15:0]             i_focal_row,
    output logic [dbc_pkg::XY_W-1:0] o_centroid_x_mm,
    output logic [dbc_pkg::XY_W-1:0] o_centroid_y_mm,
    output logic [dbc_pkg::Z_W-1:0]  o_centroid_z_mm,
    output logic [dbc_pkg::KC_W-1:0] o_kept_count,
    output logic                     o_found
);
    import dbc_pkg::*;

    localparam int DX_W   = (((COORD_BITS + 4) > 16) ? (COORD_BITS + 4) : 16) + 1;
    localparam int PROD_W = DX_W + 17;
    localparam int SL_W   = DX_W + 16 + TALLY_W;
    localparam int SD_W   = 16 + TALLY_W;
    localparam int DEN_W  = 16 + TALLY_W;

    // stage a: filter and offsets
    logic                    r_a_vld, r_a_keep, r_a_last;
    logic signed [DX_W-1:0]  r_a_dx, r_a_dy;
    logic [15:0]             r_a_d;
    // stage b: products
    logic                    r_b_vld, r_b_keep, r_b_last;
    logic signed [PROD_W-1:0] r_b_px, r_b_py;
    logic [15:0]             r_b_d;
    // sums
    logic signed [SL_W-1:0]  r_sum_lat, r_sum_vert;
    logic [SD_W-1:0]         r_sum_depth;
    logic [TALLY_W-1:0]      r_tally;
    // divider operands and quotients
    logic [SL_W-1:0]         r_dvd;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg;
    logic [XY_W-1:0]         r_qx, r_qy;
    logic [Z_W-1:0]          r_qz;
    // result register
    logic [XY_W-1:0]         r_out_x, r_out_y;
    logic [Z_W-1:0]          r_out_z;
    logic [KC_W-1:0]         r_out_cnt;
    logic                    r_out_found;

    logic                    w_keep;
    logic signed [DX_W-1:0]  w_dx, w_dy;
    logic                    w_room;
    logic signed [SL_W-1:0]  w_sum_sel;
    logic [15:0]             w_focal;
    logic [15:0]             w_focal_cl;
    logic                    w_div_done, w_div_ovf;
    logic [Q_W-1:0]          w_quo;
    logic [XY_W-1:0]         w_sat;

    function automatic logic [XY_W-1:0] sat_xy(input logic [Q_W-1:0] q, input logic ovf,
                                               input logic neg);
        logic [XY_W-1:0] v;
        if (neg) begin
            v = (ovf || (q > XY_NEG_MIN)) ? XY_NEG_MIN : XY_W'(~q + 1'b1);
        end else begin
            v = (ovf || q[Q_W-1]) ? XY_POS_MAX : q;
        end
        return v;
    endfunction

    assign w_keep = (i_depth_mm != 16'd0) && (i_depth_mm >= MIN_DEPTH_MM) &&
                    (i_depth_mm <= i_max_range_mm);
    assign w_dx = $signed(DX_W'({i_pixel_col, 4'b0000})) - $signed(DX_W'(i_center_col));
    assign w_dy = $signed(DX_W'({i_pixel_row, 4'b0000})) - $signed(DX_W'(i_center_row));
    assign w_room = (r_tally < TALLY_W'(MAX_BOX_PIXELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_take;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_keep <= w_keep;
        r_a_last <= i_box_last;
        r_a_dx   <= w_dx;
        r_a_dy   <= w_dy;
        r_a_d    <= i_depth_mm;
        r_b_keep <= r_a_keep;
        r_b_last <= r_a_last;
        r_b_px   <= r_a_dx * $signed({1'b0, r_a_d});
        r_b_py   <= r_a_dy * $signed({1'b0, r_a_d});
        r_b_d    <= r_a_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_sum_lat   <= '0;
            r_sum_vert  <= '0;
            r_sum_depth <= '0;
            r_tally     <= '0;
        end else if (r_b_vld && r_b_keep && w_room) begin
            r_sum_lat   <= r_sum_lat + SL_W'(r_b_px);
            r_sum_vert  <= r_sum_vert + SL_W'(r_b_py);
            r_sum_depth <= r_sum_depth + SD_W'(r_b_d);
            r_tally     <= r_tally + TALLY_W'(1);
        end
    end

    // operand selection for the shared divider
    assign w_sum_sel  = (i_cmd.sel == SEL_X) ? r_sum_lat : r_sum_vert;
    assign w_focal    = (i_cmd.sel == SEL_X) ? i_focal_col : i_focal_row;
    assign w_focal_cl = (w_focal < FOCAL_MIN) ? FOCAL_MIN : w_focal;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            if (i_cmd.sel == SEL_Z) begin
                r_dvd <= SL_W'(r_sum_depth);
                r_den <= DEN_W'(r_tally);
                r_neg <= 1'b0;
            end else begin
                r_dvd <= w_sum_sel[SL_W-1] ? SL_W'(-w_sum_sel) : SL_W'(w_sum_sel);
                r_den <= DEN_W'(w_focal_cl) * DEN_W'(r_tally);
                r_neg <= w_sum_sel[SL_W-1];
            end
        end
    end

    dbc_div #(
        .DVD_W (SL_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_dvd   (r_dvd),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_ovf   (w_div_ovf),
        .o_quo   (w_quo)
    );

    assign w_sat = sat_xy(w_quo, w_div_ovf, r_neg);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            unique case (i_cmd.sel)
                SEL_X:   r_qx <= w_sat;
                SEL_Y:   r_qy <= w_sat;
                default: r_qz <= Z_W'(w_quo);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // empty box gives an all-zero result
            if (r_tally == '0) begin
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_z     <= '0;
                r_out_cnt   <= '0;
                r_out_found <= 1'b0;
            end else begin
                r_out_x     <= r_qx;
                r_out_y     <= r_qy;
                r_out_z     <= r_qz;
                r_out_cnt   <= KC_W'(r_tally);
                r_out_found <= 1'b1;
            end
        end
    end

    assign o_stat.last_done  = r_b_vld && r_b_last;
    assign o_stat.tally_zero = (r_tally == '0);
    assign o_stat.div_done   = w_div_done;

    assign o_centroid_x_mm = r_out_x;
    assign o_centroid_y_mm = r_out_y;
    assign o_centroid_z_mm = r_out_z;
    assign o_kept_count    = r_out_cnt;
    assign o_found         = r_out_found;

endmodule

// ===== rtl/core/dbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbc_ctrl
// Sequencer: opens pixel intake, waits for the last pixel to drain, runs the
// three divisions on the shared divider unless the box is empty, and hands the result to the output.
// ----------------------------------------------------------------------------
module dbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  logic                i_out_ready,
    input  dbc_pkg::t_dbc_stat  i_stat,
    output dbc_pkg::t_dbc_cmd   o_cmd,
    output logic                o_out_valid
);
    import dbc_pkg::*;

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    t_sel       r_sel, n_sel;
    logic       r_out_vld, n_out_vld;
    t_dbc_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        w_cmd   = '0;
        w_cmd.sel = r_sel;
        unique case (r_state)
            S_ACC: begin
                w_cmd.ready = 1'b1;
                if (i_in_valid && i_in_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.last_done) begin
                    n_state = S_PREP;
                    n_sel   = SEL_X;
                end
            end
            S_PREP: begin
                if (i_stat.tally_zero) begin
                    n_state = S_FIN;
                end else begin
                    w_cmd.prep = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                w_cmd.start = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (i_stat.div_done) begin
                    w_cmd.store = 1'b1;
                    if (r_sel == SEL_Z) begin
                        n_state = S_FIN;
                    end else begin
                        n_sel   = (r_sel == SEL_X) ? SEL_Y : SEL_Z;
                        n_state = S_PREP;
                    end
                end
            end
            S_FIN: begin
                // wait until the result register is free
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.load = 1'b1;
                    w_cmd.clr  = 1'b1;
                    n_state    = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_cmd.load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_sel     <= SEL_X;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_vld;

endmodule

// ===== rtl/core/depth_box_centroid.sv =====
// ----------------------------------------------------------------------------
// depth_box_centroid
// 3-D centroid of the depth pixels of one bounding box by pinhole
// back-projection, with an APB register port for range and camera intrinsics.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while a box streams in, intake closed after the last pixel
// after the last pixel transfer: the multiply pipeline drains, the shared 19-step restoring divider
//   runs three divisions, then the result loads; the divisions are skipped with no kept pixel
// a result still held at load time stalls the next box
// reset: synchronous; registers return to defaults, sums clear, no clear pass
module depth_box_centroid #(
    parameter int MAX_BOX_PIXELS = 1048576,
    parameter int COORD_BITS     = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // depth_mm, pixel_col, pixel_row
    input  logic [((16 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tlast,
    output logic                      o_s_tready,
    // centroid_x_mm, centroid_y_mm, centroid_z_mm, kept_count, zero pad
    output logic [79:0]               o_m_tdata,
    // found
    output logic [0:0]                o_m_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import dbc_pkg::*;

    localparam int TALLY_W = $clog2(MAX_BOX_PIXELS + 1);

    logic [15:0] r_max_range, r_center_col, r_center_row, r_focal_col, r_focal_row;

    t_dbc_cmd    w_cmd;
    t_dbc_stat   w_stat;
    logic        w_take;
    logic        w_wr;
    logic [2:0]  w_idx;
    logic [XY_W-1:0] w_x, w_y;
    logic [Z_W-1:0]  w_z;
    logic [KC_W-1:0] w_cnt;
    logic            w_found;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range  <= RST_MAX_RANGE;
            r_center_col <= RST_CENTER_COL;
            r_center_row <= RST_CENTER_ROW;
            r_focal_col  <= RST_FOCAL_COL;
            r_focal_row  <= RST_FOCAL_ROW;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_RANGE:  r_max_range  <= pwdata[15:0];
                REG_CENTER_COL: r_center_col <= pwdata[15:0];
                REG_CENTER_ROW: r_center_row <= pwdata[15:0];
                REG_FOCAL_COL:  r_focal_col  <= pwdata[15:0];
                REG_FOCAL_ROW:  r_focal_row  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAX_RANGE:  prdata = {16'd0, r_max_range};
            REG_CENTER_COL: prdata = {16'd0, r_center_col};
            REG_CENTER_ROW: prdata = {16'd0, r_center_row};
            REG_FOCAL_COL:  prdata = {16'd0, r_focal_col};
            REG_FOCAL_ROW:  prdata = {16'd0, r_focal_row};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_s_tready = w_cmd.ready;
    assign w_take     = i_s_tvalid && w_cmd.ready;

    dbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_last   (i_s_tlast),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_out_valid (o_m_tvalid)
    );

    dbc_datapath #(
        .COORD_BITS     (COORD_BITS),
        .MAX_BOX_PIXELS (MAX_BOX_PIXELS),
        .TALLY_W        (TALLY_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_take          (w_take),
        .i_depth_mm      (i_s_tdata[15:0]),
        .i_pixel_col     (i_s_tdata[16 +: COORD_BITS]),
        .i_pixel_row     (i_s_tdata[16 + COORD_BITS +: COORD_BITS]),
        .i_box_last      (i_s_tlast),
        .i_max_range_mm  (r_max_range),
        .i_center_col    (r_center_col),
        .i_center_row    (r_center_row),
        .i_focal_col     (r_focal_col),
        .i_focal_row     (r_focal_row),
        .o_centroid_x_mm (w_x),
        .o_centroid_y_mm (w_y),
        .o_centroid_z_mm (w_z),
        .o_kept_count    (w_cnt),
        .o_found         (w_found)
    );

    assign o_m_tdata = {5'd0, w_cnt, w_z, w_y, w_x};
    assign o_m_tuser = w_found;

    // intake stays closed while the divider runs
    a_div_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> !o_s_tready)
        else $error("pixel intake open during division");

    // last pixel of a box closes intake on the next cycle
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("intake still open after last pixel");

    // an empty box reports all zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == 80'd0))
        else $error("not-found result carries nonzero data");

    // a new result is loaded only when the previous one is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten before transfer");

endmodule
